// ===== design/b64enc_pkg.sv =====
`timescale 1ns / 1ps

package b64enc_pkg;

  // Position within the current three-byte group.
  typedef enum logic [1:0] {
    PH_0,
    PH_1,
    PH_2
  } b64enc_phase_t;

  localparam logic [6:0] PAD_CHAR = 7'h3D;  // '='

  // All characters that one input byte produces. Only the final character
  // of a bundle can carry the end-of-message flag.
  typedef struct packed {
    logic [3:0][6:0] chars;   // chars[0] goes out first
    logic [1:0]      cnt_m1;  // number of valid characters minus one
    logic            fin;     // final character ends the message
  } b64enc_bundle_t;

  // Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] vv;
    logic [6:0] ch;
    vv = {1'b0, v};
    if (v < 6'd26) begin
      ch = 7'h41 + vv;
    end else if (v < 6'd52) begin
      ch = 7'h47 + vv;
    end else if (v < 6'd62) begin
      ch = vv - 7'd4;
    end else if (v == 6'd62) begin
      ch = 7'h2B;
    end else begin
      ch = 7'h2F;
    end
    return ch;
  endfunction

endpackage

// ===== design/b64enc_front.sv =====
`timescale 1ns / 1ps

module b64enc_front
  import b64enc_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  input  logic           last_byte,
  input  logic           q_full,
  output logic           in_ready,
  output logic           push,
  output b64enc_bundle_t push_data
);

  b64enc_phase_t phase, phase_next;
  logic [3:0]    carry, carry_next;
  logic          emits;

  assign in_ready = !q_full;

  always_comb begin
    push_data.chars  = {4{PAD_CHAR}};
    push_data.cnt_m1 = 2'd0;
    push_data.fin    = last_byte;
    phase_next       = PH_0;
    carry_next       = 4'd0;
    emits            = 1'b1;
    unique case (phase)
      PH_1: begin
        push_data.chars[0] = sextet_char({carry[1:0], in_byte[7:4]});
        if (last_byte) begin
          push_data.chars[1] = sextet_char({in_byte[3:0], 2'b00});
          push_data.cnt_m1   = 2'd2;
        end else begin
          phase_next = PH_2;
          carry_next = in_byte[3:0];
        end
      end
      PH_2: begin
        push_data.chars[0] = sextet_char({carry, in_byte[7:6]});
        push_data.chars[1] = sextet_char(in_byte[5:0]);
        push_data.cnt_m1   = 2'd1;
      end
      default: begin
        // The unused phase code behaves as the start of a group.
        push_data.chars[0] = sextet_char(in_byte[7:2]);
        if (last_byte) begin
          push_data.chars[1] = sextet_char({in_byte[1:0], 4'b0000});
          push_data.cnt_m1   = 2'd3;
        end else begin
          phase_next = PH_1;
          carry_next = {2'b00, in_byte[1:0]};
        end
      end
    endcase
  end

  assign push = in_valid && in_ready && emits;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_0;
      carry <= 4'd0;
    end else if (in_valid && in_ready) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

// ===== design/b64enc_fifo.sv =====
`timescale 1ns / 1ps

module b64enc_fifo
  import b64enc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64enc_bundle_t push_data,
  output logic           full,
  output logic           q_valid,
  output b64enc_bundle_t q_data,
  input  logic           pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64enc_bundle_t slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !q_valid))
    else $error("pop from an empty queue");

endmodule

// ===== design/b64enc_back.sv =====
`timescale 1ns / 1ps

module b64enc_back
  import b64enc_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  b64enc_bundle_t q_data,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     out_char,
  output logic           last_char
);

  b64enc_bundle_t cur;
  logic           busy;
  logic [1:0]     idx;
  logic           out_free;
  logic           issue;
  logic           done;

  assign out_free = !out_valid || out_ready;
  assign issue    = busy && out_free;
  assign done     = issue && (idx == cur.cnt_m1);
  assign pop      = q_valid && (!busy || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= issue;
      end
      if (pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (issue) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
    if (issue) begin
      out_char  <= cur.chars[idx];
      last_char <= cur.fin && (idx == cur.cnt_m1);
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= cur.cnt_m1))
    else $error("character index past end of bundle");

  a_issue_fills_output: assert property (@(posedge clk) disable iff (rst)
    issue |=> out_valid)
    else $error("issued character not presented");

  a_pop_only_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!busy || done))
    else $error("bundle loaded over one in progress");

endmodule

// ===== design/base64_stream_encoder_core.sv =====
`timescale 1ns / 1ps

// Base64 stream encoder, standard alphabet with '=' padding.
// Input channel s_*: one raw byte per beat in s_tdata, s_tlast marks the final
// byte of a message. Output channel m_*: one ASCII character per beat in
// m_tdata[6:0] (bit 7 is zero), m_tlast marks the final character.
// A front stage classifies each byte against the group phase and produces all
// characters it completes (one to four) as one bundle; a small queue holds
// bundles; a back stage sends them out one character per cycle.
// Throughput: one byte per cycle on input while the queue has room; while
// m_tready is high the output register sends one character per cycle, so a
// steady stream runs at four output beats per three input bytes, and a final
// byte produces up to four characters. On an empty path a character's byte
// passes the queue, the bundle register and the output register to m_*.
// When the receiver stalls, the output register holds its beat, the back stage
// stops, the queue fills, and then s_tready drops until space frees up.
// Reset (rst, synchronous) empties the queue and output register and returns
// the encoder to the start of a group.

module base64_stream_encoder_core
  import b64enc_pkg::*;
#(
  parameter int FIFO_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output logic       m_tlast    // last_char
);

  b64enc_bundle_t push_data;
  b64enc_bundle_t q_data;
  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           pop;
  logic [6:0]     out_char;

  b64enc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .last_byte (s_tlast),
    .q_full    (q_full),
    .in_ready  (s_tready),
    .push      (push),
    .push_data (push_data)
  );

  b64enc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop)
  );

  b64enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (out_char),
    .last_char (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

endmodule
